// ===== hw/rtl/lt2gps_pkg.sv =====
package lt2gps_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OFFSET_W = 5;
    localparam int WEEK_W   = 13;
    localparam int SOW_W    = 20;

    localparam logic [OFFSET_W-1:0] UTC_OFFSET_RESET = 5'd8;
    localparam logic [OFFSET_W-1:0] UTC_OFFSET_MAX   = 5'd23;

    localparam int LEAP_ENTRIES_DEFAULT = 16;
    localparam int LEAP_TABLE_SIZE      = 32;
    localparam int NEVER_THRESHOLD      = 131071;

    // Threshold is UTC year * 12 + first UTC month that includes the leap second.
    localparam int LEAP_THRESHOLD [LEAP_TABLE_SIZE] = '{
        1981 * 12 + 7, 1982 * 12 + 7, 1983 * 12 + 7, 1985 * 12 + 7,
        1988 * 12 + 1, 1990 * 12 + 1, 1991 * 12 + 1, 1992 * 12 + 7,
        1993 * 12 + 7, 1994 * 12 + 7, 1996 * 12 + 1, 1997 * 12 + 7,
        1999 * 12 + 1, 2006 * 12 + 1, 2009 * 12 + 1, 2012 * 12 + 7,
        NEVER_THRESHOLD, NEVER_THRESHOLD, NEVER_THRESHOLD, NEVER_THRESHOLD,
        NEVER_THRESHOLD, NEVER_THRESHOLD, NEVER_THRESHOLD, NEVER_THRESHOLD,
        NEVER_THRESHOLD, NEVER_THRESHOLD, NEVER_THRESHOLD, NEVER_THRESHOLD,
        NEVER_THRESHOLD, NEVER_THRESHOLD, NEVER_THRESHOLD, NEVER_THRESHOLD
    };

    localparam int YEAR_BIAS      = 4800;
    localparam int EPOCH_DAY_BIAS = 2476412;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_WEEK  = 604800;

    // Reciprocals for division by 100 and by 7 with the matching shifts.
    localparam int RECIP_100       = 10486;
    localparam int RECIP_100_SHIFT = 20;
    localparam int RECIP_7         = 1198373;
    localparam int RECIP_7_SHIFT   = 23;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } request_t;

    typedef struct packed {
        logic [WEEK_W-1:0] gps_week;
        logic [SOW_W-1:0]  seconds_of_week;
        logic              before_epoch;
    } result_t;

    // Month term (306 * (m + 1)) / 10 with January and February moved to months 13 and 14.
    function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] month);
        logic [8:0] term;
        unique case (month)
            4'd0:    term = 9'd397;
            4'd1:    term = 9'd428;
            4'd2:    term = 9'd459;
            4'd3:    term = 9'd122;
            4'd4:    term = 9'd153;
            4'd5:    term = 9'd183;
            4'd6:    term = 9'd214;
            4'd7:    term = 9'd244;
            4'd8:    term = 9'd275;
            4'd9:    term = 9'd306;
            4'd10:   term = 9'd336;
            4'd11:   term = 9'd367;
            4'd12:   term = 9'd397;
            4'd13:   term = 9'd428;
            4'd14:   term = 9'd459;
            default: term = 9'd489;
        endcase
        return term;
    endfunction

endpackage

// ===== hw/rtl/local_time_to_gps_week_seconds_core.sv =====
// Converts a local calendar date and time into GPS week and seconds of week, adding the
// leap seconds in force at the UTC month. The block is a six stage pipeline that takes one
// request per clock cycle: busy is always low, and each result appears on result with done
// high for one cycle, in request order, once it has passed stages s1 to s5 and the result
// register. The two reciprocal multiplications (by 1/100 for centuries and by 1/7 for weeks)
// each fill a stage. The receiver cannot stall the pipeline, so done must be taken when it
// is shown. The UTC offset register accepts a write in every cycle and must only be written
// while no request is in flight.
module local_time_to_gps_week_seconds_core
    import lt2gps_pkg::*;
#(
    parameter int LEAP_ENTRIES = LEAP_ENTRIES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  request_t            request,
    output logic                done,
    output result_t             result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [OFFSET_W-1:0] cfg_data
);

    localparam int LEAP_W = $clog2(LEAP_ENTRIES + 1);
    localparam int YADJ_W = 14;
    localparam int MD_W   = 10;
    localparam int T_W    = 18;
    localparam int KEY_W  = 18;
    localparam int CENT_W = 8;
    localparam int Y4_W   = 23;
    localparam int DAYS_W = 21;
    localparam int X_W    = 20;
    localparam int Q_W    = 18;
    localparam int RAW_W  = 21;

    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_sat;

    logic                     s1_valid_reg;
    logic [YADJ_W-1:0]        s1_yadj_reg;
    logic [YADJ_W-1:0]        s1_yadj_next;
    logic [MD_W-1:0]          s1_md_reg;
    logic [MD_W-1:0]          s1_md_next;
    logic signed [T_W-1:0]    s1_t_reg;
    logic signed [T_W-1:0]    s1_t_next;
    logic signed [KEY_W-1:0]  s1_key_reg;
    logic signed [KEY_W-1:0]  s1_key_next;

    logic                     s2_valid_reg;
    logic [CENT_W-1:0]        s2_cent_reg;
    logic [CENT_W-1:0]        s2_cent_next;
    logic [Y4_W-1:0]          s2_y4_reg;
    logic [Y4_W-1:0]          s2_y4_next;
    logic [LEAP_ENTRIES-1:0]  s2_hits_reg;
    logic [LEAP_ENTRIES-1:0]  s2_hits_next;
    logic [MD_W-1:0]          s2_md_reg;
    logic signed [T_W-1:0]    s2_t_reg;

    logic                     s3_valid_reg;
    logic signed [DAYS_W-1:0] s3_days_reg;
    logic signed [DAYS_W-1:0] s3_days_next;
    logic signed [T_W-1:0]    s3_s_reg;
    logic signed [T_W-1:0]    s3_s_next;
    logic signed [T_W-1:0]    s3_t_reg;

    logic                     s4_valid_reg;
    logic [X_W-1:0]           s4_x_reg;
    logic [X_W-1:0]           s4_x_next;
    logic [Q_W-1:0]           s4_q_reg;
    logic [Q_W-1:0]           s4_q_next;
    logic signed [T_W-1:0]    s4_s_reg;
    logic                     s4_before_reg;
    logic                     s4_before_next;

    logic                     s5_valid_reg;
    logic [WEEK_W-1:0]        s5_week_reg;
    logic [WEEK_W-1:0]        s5_week_next;
    logic signed [RAW_W-1:0]  s5_raw_reg;
    logic signed [RAW_W-1:0]  s5_raw_next;
    logic                     s5_before_reg;

    logic                     done_reg;
    result_t                  result_reg;
    result_t                  result_next;

    logic                     accept;
    logic [16:0]              tod_pos;
    logic [16:0]              off_secs;
    logic                     borrow;
    logic [15:0]              year12;
    logic [27:0]              cent_prod;
    logic [24:0]              y1461_prod;
    logic signed [24:0]       days_sum;
    logic [LEAP_W-1:0]        leap_cnt;
    logic [40:0]              q_prod;
    logic [X_W-1:0]           rem_full;
    logic [2:0]               rem;
    logic [19:0]              rem_secs;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = result_reg;

    assign offset_sat = (offset_reg > UTC_OFFSET_MAX) ? UTC_OFFSET_MAX : offset_reg;

    always_comb
    begin
        s1_yadj_next = YADJ_W'(request.year) + YADJ_W'(YEAR_BIAS)
                     - YADJ_W'(request.month <= 4'd2);
        s1_md_next   = MD_W'(month_term(request.month)) + MD_W'(request.day_of_month);
        tod_pos      = 17'(request.hour) * 17'(SECS_PER_HOUR)
                     + 17'(request.minute) * 17'(SECS_PER_MIN) + 17'(request.second);
        off_secs     = 17'(offset_sat) * 17'(SECS_PER_HOUR);
        s1_t_next    = $signed({1'b0, tod_pos}) - $signed({1'b0, off_secs});
        borrow       = (request.hour < offset_sat) && (request.day_of_month == 5'd1);
        year12       = 16'(request.year) * 16'd12;
        s1_key_next  = $signed({2'b00, year12}) + $signed(KEY_W'(request.month))
                     - $signed(KEY_W'(borrow));
    end

    always_comb
    begin
        cent_prod    = 28'(s1_yadj_reg) * 28'(RECIP_100);
        s2_cent_next = cent_prod[RECIP_100_SHIFT +: CENT_W];
        y1461_prod   = 25'(s1_yadj_reg) * 25'd1461;
        s2_y4_next   = y1461_prod[24:2];
        for (int i = 0; i < LEAP_ENTRIES; i++)
        begin
            s2_hits_next[i] = s1_key_reg >= $signed(KEY_W'(LEAP_THRESHOLD[i]));
        end
    end

    always_comb
    begin
        days_sum     = $signed({2'b00, s2_y4_reg})
                     + $signed(25'(s2_cent_reg[CENT_W-1:2]))
                     - $signed(25'(s2_cent_reg))
                     + $signed(25'(s2_md_reg))
                     - $signed(25'(EPOCH_DAY_BIAS));
        s3_days_next = days_sum[DAYS_W-1:0];
        leap_cnt     = '0;
        for (int i = 0; i < LEAP_ENTRIES; i++)
        begin
            leap_cnt = leap_cnt + LEAP_W'(s2_hits_reg[i]);
        end
        s3_s_next    = s2_t_reg + $signed(T_W'(leap_cnt));
    end

    // The day count is biased by one week so the quotient stays positive for every
    // time at or after the epoch; the next stage takes the week back off.
    always_comb
    begin
        s4_x_next      = X_W'(s3_days_reg) + X_W'(7);
        q_prod         = 41'(s4_x_next) * 41'(RECIP_7);
        s4_q_next      = q_prod[RECIP_7_SHIFT +: Q_W];
        s4_before_next = (s3_days_reg < -21'sd1)
                      || ((s3_days_reg == -21'sd1) && (s3_t_reg < T_W'(SECS_PER_DAY)))
                      || ((s3_days_reg == 21'sd0) && (s3_t_reg < 18'sd0));
    end

    always_comb
    begin
        rem_full     = s4_x_reg - X_W'(s4_q_reg) * X_W'(7);
        rem          = rem_full[2:0];
        rem_secs     = 20'(rem) * 20'(SECS_PER_DAY);
        s5_raw_next  = $signed({1'b0, rem_secs}) + $signed(RAW_W'(s4_s_reg));
        s5_week_next = s4_q_reg[WEEK_W-1:0] - WEEK_W'(1);
    end

    always_comb
    begin
        result_next = '0;
        priority if (s5_before_reg)
        begin
            result_next.before_epoch = 1'b1;
        end
        else if (s5_raw_reg < 21'sd0)
        begin
            result_next.gps_week        = s5_week_reg - WEEK_W'(1);
            result_next.seconds_of_week = SOW_W'(s5_raw_reg + RAW_W'(SECS_PER_WEEK));
        end
        else if (s5_raw_reg >= RAW_W'(SECS_PER_WEEK))
        begin
            result_next.gps_week        = s5_week_reg + WEEK_W'(1);
            result_next.seconds_of_week = SOW_W'(s5_raw_reg - RAW_W'(SECS_PER_WEEK));
        end
        else
        begin
            result_next.gps_week        = s5_week_reg;
            result_next.seconds_of_week = SOW_W'(s5_raw_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= UTC_OFFSET_RESET;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= cfg_data;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            done_reg     <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_yadj_reg <= s1_yadj_next;
            s1_md_reg   <= s1_md_next;
            s1_t_reg    <= s1_t_next;
            s1_key_reg  <= s1_key_next;
        end
        if (s1_valid_reg)
        begin
            s2_cent_reg <= s2_cent_next;
            s2_y4_reg   <= s2_y4_next;
            s2_hits_reg <= s2_hits_next;
            s2_md_reg   <= s1_md_reg;
            s2_t_reg    <= s1_t_reg;
        end
        if (s2_valid_reg)
        begin
            s3_days_reg <= s3_days_next;
            s3_s_reg    <= s3_s_next;
            s3_t_reg    <= s2_t_reg;
        end
        if (s3_valid_reg)
        begin
            s4_x_reg      <= s4_x_next;
            s4_q_reg      <= s4_q_next;
            s4_s_reg      <= s3_s_reg;
            s4_before_reg <= s4_before_next;
        end
        if (s4_valid_reg)
        begin
            s5_week_reg   <= s5_week_next;
            s5_raw_reg    <= s5_raw_next;
            s5_before_reg <= s4_before_reg;
        end
        if (s5_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb
    import lt2gps_pkg::*;
();

    localparam int IDLE_LIMIT   = 1000;
    localparam int PIPE_LATENCY = 6;
    localparam int LEAP_COUNT   = 16;
    localparam int SECS_IN_WEEK = 604800;

    localparam int LEAP_MONTH_KEY [LEAP_COUNT] = '{
        1981 * 12 + 7, 1982 * 12 + 7, 1983 * 12 + 7, 1985 * 12 + 7,
        1988 * 12 + 1, 1990 * 12 + 1, 1991 * 12 + 1, 1992 * 12 + 7,
        1993 * 12 + 7, 1994 * 12 + 7, 1996 * 12 + 1, 1997 * 12 + 7,
        1999 * 12 + 1, 2006 * 12 + 1, 2009 * 12 + 1, 2012 * 12 + 7
    };

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    request_t            request;
    logic                done;
    result_t             result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [OFFSET_W-1:0] cfg_data;

    logic [OFFSET_W-1:0] utc_offset;
    result_t             pending_gps_times[$];
    int                  error_count = 0;
    int                  idle_cycles = 0;
    int                  burst_left = 0;

    local_time_to_gps_week_seconds_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic result_t predict_gps_time(input request_t item,
                                                 input logic [OFFSET_W-1:0] offset_reg);
        longint  off;
        longint  yr;
        longint  mo;
        longint  dy;
        longint  hr;
        longint  mi;
        longint  se;
        longint  uyear;
        longint  umonth;
        longint  y;
        longint  m;
        longint  cent;
        longint  days;
        longint  total;
        longint  key;
        longint  leaps;
        longint  gps;
        result_t res;
        off = (offset_reg > UTC_OFFSET_MAX) ? longint'(UTC_OFFSET_MAX) : longint'(offset_reg);
        yr = item.year;
        mo = item.month;
        dy = item.day_of_month;
        hr = item.hour;
        mi = item.minute;
        se = item.second;
        uyear = yr;
        umonth = mo;
        if (hr < off && dy == 1)
        begin
            if (mo == 1)
            begin
                umonth = 12;
                uyear = yr - 1;
            end
            else
            begin
                umonth = mo - 1;
            end
        end
        y = yr + 4800;
        m = mo;
        if (m <= 2)
        begin
            m = m + 12;
            y = y - 1;
        end
        cent = y / 100;
        days = cent / 4 - cent + (1461 * y) / 4 + (306 * (m + 1)) / 10 + dy - 2476412;
        total = days * 86400 + hr * 3600 + mi * 60 + se - off * 3600;
        res = '0;
        if (total < 0)
        begin
            res.before_epoch = 1'b1;
        end
        else
        begin
            key = uyear * 12 + umonth;
            leaps = 0;
            for (int i = 0; i < LEAP_COUNT; i++)
            begin
                if (key >= LEAP_MONTH_KEY[i])
                    leaps = leaps + 1;
            end
            gps = total + leaps;
            res.gps_week = WEEK_W'(gps / SECS_IN_WEEK);
            res.seconds_of_week = SOW_W'(gps % SECS_IN_WEEK);
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_gps_times.size() == 0)
            begin
                $error("unexpected result: gps_week %0d seconds_of_week %0d before_epoch %0d",
                       result.gps_week, result.seconds_of_week, result.before_epoch);
                error_count++;
            end
            else
            begin
                want = pending_gps_times.pop_front();
                if (result.gps_week !== want.gps_week)
                begin
                    $error("gps_week: expected %0d, got %0d", want.gps_week, result.gps_week);
                    error_count++;
                end
                if (result.seconds_of_week !== want.seconds_of_week)
                begin
                    $error("seconds_of_week: expected %0d, got %0d",
                           want.seconds_of_week, result.seconds_of_week);
                    error_count++;
                end
                if (result.before_epoch !== want.before_epoch)
                begin
                    $error("before_epoch: expected %0d, got %0d",
                           want.before_epoch, result.before_epoch);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("local_time_to_gps_week_seconds_core regression: fail");
            $finish;
        end
    end

    task automatic send_request(input request_t item);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= item;
        do @(posedge clk); while (busy);
        pending_gps_times.push_back(predict_gps_time(item, utc_offset));
    endtask

    task automatic send_local_time(input int yr, input int mo, input int dy,
                                   input int hr, input int mi, input int se);
        request_t item;
        item.year = YEAR_W'(yr);
        item.month = MONTH_W'(mo);
        item.day_of_month = DAY_W'(dy);
        item.hour = HOUR_W'(hr);
        item.minute = MINUTE_W'(mi);
        item.second = SECOND_W'(se);
        send_request(item);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] value);
        start <= 1'b0;
        while (pending_gps_times.size() != 0) @(posedge clk);
        repeat ($urandom_range(0, 9)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        utc_offset = value;
    endtask

    task automatic test_epoch_boundary();
        send_local_time(1980, 1, 6, 8, 0, 0);
        send_local_time(1980, 1, 6, 7, 59, 59);
        send_local_time(1980, 1, 13, 8, 0, 0);
        send_local_time(1980, 1, 6, 0, 0, 0);
    endtask

    task automatic test_field_extremes();
        send_local_time(0, 0, 0, 0, 0, 0);
        send_local_time(4095, 15, 31, 31, 63, 63);
        send_local_time(2099, 12, 31, 23, 59, 59);
        send_local_time(2000, 0, 1, 0, 0, 0);
        send_local_time(2001, 13, 1, 3, 10, 20);
        send_local_time(2002, 14, 0, 30, 61, 62);
        send_local_time(1999, 15, 1, 7, 0, 0);
    endtask

    task automatic test_leap_boundaries();
        send_local_time(1981, 7, 1, 7, 59, 59);
        send_local_time(1981, 7, 1, 8, 0, 0);
        send_local_time(2012, 7, 1, 8, 0, 0);
        send_local_time(1988, 1, 1, 0, 0, 0);
        send_local_time(1988, 1, 1, 8, 0, 0);
        send_local_time(2017, 1, 1, 0, 0, 0);
    endtask

    task automatic test_offset_extremes();
        write_offset(5'd0);
        send_local_time(1980, 1, 6, 0, 0, 0);
        send_local_time(2012, 7, 1, 0, 0, 0);
        write_offset(UTC_OFFSET_MAX);
        send_local_time(1980, 1, 6, 23, 0, 0);
        send_local_time(2000, 3, 1, 22, 59, 59);
        write_offset(5'd31);
        send_local_time(1980, 1, 6, 23, 0, 0);
        write_offset(5'd24);
        send_local_time(1990, 1, 1, 12, 0, 0);
    endtask

    task automatic test_random_traffic();
        logic [OFFSET_W-1:0] phase_offset [6];
        request_t            item;
        int                  kind;
        phase_offset[0] = UTC_OFFSET_RESET;
        phase_offset[1] = 5'd0;
        phase_offset[2] = OFFSET_W'($urandom_range(1, 22));
        phase_offset[3] = UTC_OFFSET_MAX;
        phase_offset[4] = OFFSET_W'($urandom_range(24, 31));
        phase_offset[5] = OFFSET_W'($urandom_range(0, 23));
        for (int p = 0; p < 6; p++)
        begin
            write_offset(phase_offset[p]);
            repeat (150)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 2)
                begin
                    item.year = YEAR_W'($urandom);
                    item.month = MONTH_W'($urandom);
                    item.day_of_month = DAY_W'($urandom);
                    item.hour = HOUR_W'($urandom);
                    item.minute = MINUTE_W'($urandom);
                    item.second = SECOND_W'($urandom);
                end
                else
                begin
                    item.year = YEAR_W'($urandom_range(1980, 2099));
                    item.month = MONTH_W'($urandom_range(1, 12));
                    item.day_of_month = DAY_W'($urandom_range(0, 3) == 0 ? 1
                                                : $urandom_range(1, 31));
                    if (kind == 2)
                    begin
                        item.year = YEAR_W'(1980);
                        item.month = MONTH_W'(1);
                        item.day_of_month = DAY_W'($urandom_range(1, 7));
                    end
                    item.hour = HOUR_W'($urandom_range(0, 23));
                    item.minute = MINUTE_W'($urandom_range(0, 59));
                    item.second = SECOND_W'($urandom_range(0, 59));
                end
                send_request(item);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        utc_offset = UTC_OFFSET_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_epoch_boundary();
        test_field_extremes();
        test_leap_boundaries();
        test_offset_extremes();
        test_random_traffic();
        start <= 1'b0;
        while (pending_gps_times.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY * 4) @(posedge clk);
        if (error_count == 0)
            $display("local_time_to_gps_week_seconds_core regression: pass");
        else
            $display("local_time_to_gps_week_seconds_core regression: fail");
        $finish;
    end

endmodule
